@@ hw/rtl/clsm_pkg.sv @@
// Shared types, codes and helper functions of the cell load state monitor.
package clsm_pkg;

  localparam int USER_BITS_DEF  = 10;
  localparam int COUNT_BITS_DEF = 8;

  localparam int FACTOR_W    = 16;
  localparam int THRESH_W    = 28;
  localparam int FCOUNT_W    = 8;
  localparam int LOAD_OUT_W  = 27;
  localparam int RUN_OUT_W   = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_DCH_FACTOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARED_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT  = 3'd4;

  localparam logic [FCOUNT_W-1:0] FILTER_COUNT_RST = 8'd2;

  localparam logic [1:0] BW_0K    = 2'd0;
  localparam logic [1:0] BW_600K  = 2'd1;
  localparam logic [1:0] BW_1200K = 2'd2;

  typedef enum logic [1:0] {
    ST_LOW    = 2'd0,
    ST_MEDIUM = 2'd1,
    ST_HIGH   = 2'd2
  } load_state_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] dch_factor;
    logic [FACTOR_W-1:0] shared_factor;
    logic [THRESH_W-1:0] medium_thresh;
    logic [THRESH_W-1:0] high_thresh;
    logic [FCOUNT_W-1:0] filter_count;
  } cfg_t;

  function automatic load_state_t bw_to_state(input logic [1:0] bw);
    load_state_t st;
    case (bw)
      BW_0K:   st = ST_HIGH;
      BW_600K: st = ST_MEDIUM;
      default: st = ST_LOW;
    endcase
    return st;
  endfunction

  function automatic logic [1:0] state_to_bw(input load_state_t st);
    logic [1:0] bw;
    case (st)
      ST_HIGH:   bw = BW_0K;
      ST_MEDIUM: bw = BW_600K;
      default:   bw = BW_1200K;
    endcase
    return bw;
  endfunction

endpackage

@@ hw/rtl/clsm_cfg_regs.sv @@
// Configuration register file of the cell load state monitor.
module clsm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [clsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output clsm_pkg::cfg_t                  cfg
);

  clsm_pkg::cfg_t cfg_r;
  clsm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        clsm_pkg::CFG_DCH_FACTOR:
          cfg_nxt.dch_factor = cfg_wdata[clsm_pkg::FACTOR_W-1:0];
        clsm_pkg::CFG_SHARED_FACTOR:
          cfg_nxt.shared_factor = cfg_wdata[clsm_pkg::FACTOR_W-1:0];
        clsm_pkg::CFG_MEDIUM_THRESH:
          cfg_nxt.medium_thresh = cfg_wdata[clsm_pkg::THRESH_W-1:0];
        clsm_pkg::CFG_HIGH_THRESH:
          cfg_nxt.high_thresh = cfg_wdata[clsm_pkg::THRESH_W-1:0];
        clsm_pkg::CFG_FILTER_COUNT:
          cfg_nxt.filter_count = cfg_wdata[clsm_pkg::FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dch_factor    <= '0;
      cfg_r.shared_factor <= '0;
      cfg_r.medium_thresh <= '0;
      cfg_r.high_thresh   <= '0;
      cfg_r.filter_count  <= clsm_pkg::FILTER_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/clsm_load_calc.sv @@
// Weighted cell load, threshold classification and load field saturation.
module clsm_load_calc #(
  parameter int USER_BITS = clsm_pkg::USER_BITS_DEF
) (
  input  logic [USER_BITS-1:0]              dch_users,
  input  logic [USER_BITS-1:0]              shared_users,
  input  logic                              has_access_channel,
  input  clsm_pkg::cfg_t                    cfg,
  output logic [clsm_pkg::LOAD_OUT_W-1:0]   cell_load,
  output clsm_pkg::load_state_t             load_state
);

  localparam int DCH_W  = USER_BITS + clsm_pkg::FACTOR_W;
  localparam int SHR_W  = USER_BITS + 1;
  localparam int SHRP_W = SHR_W + clsm_pkg::FACTOR_W;
  localparam int LOAD_W = SHRP_W + 1;
  localparam int CMP_W  = (LOAD_W > clsm_pkg::THRESH_W) ? LOAD_W : clsm_pkg::THRESH_W;
  localparam logic [CMP_W-1:0] FIELD_MAX =
    CMP_W'((64'd1 << clsm_pkg::LOAD_OUT_W) - 64'd1);

  logic [SHR_W-1:0]  shr;
  logic [DCH_W-1:0]  dch_prod;
  logic [SHRP_W-1:0] shr_prod;
  logic [CMP_W-1:0]  load;

  assign shr      = SHR_W'(shared_users) + SHR_W'(has_access_channel);
  assign dch_prod = DCH_W'(dch_users) * DCH_W'(cfg.dch_factor);
  assign shr_prod = SHRP_W'(shr) * SHRP_W'(cfg.shared_factor);
  assign load     = CMP_W'(LOAD_W'(dch_prod) + LOAD_W'(shr_prod));

  always_comb begin
    if (load >= CMP_W'(cfg.high_thresh)) begin
      load_state = clsm_pkg::ST_HIGH;
    end else if (load >= CMP_W'(cfg.medium_thresh)) begin
      load_state = clsm_pkg::ST_MEDIUM;
    end else begin
      load_state = clsm_pkg::ST_LOW;
    end
  end

  assign cell_load = (load > FIELD_MAX) ? FIELD_MAX[clsm_pkg::LOAD_OUT_W-1:0]
                                        : load[clsm_pkg::LOAD_OUT_W-1:0];

endmodule

@@ hw/rtl/clsm_run_filter.sv @@
// Lower-state run counter and next state selection.
module clsm_run_filter #(
  parameter int COUNT_BITS = clsm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  clsm_pkg::load_state_t           load_state,
  input  logic [1:0]                      applied_bandwidth,
  input  logic [clsm_pkg::FCOUNT_W-1:0]   filter_count,
  output clsm_pkg::load_state_t           next_state,
  output logic [clsm_pkg::RUN_OUT_W-1:0]  lower_run
);

  localparam int CW = (COUNT_BITS > clsm_pkg::FCOUNT_W) ? COUNT_BITS : clsm_pkg::FCOUNT_W;

  logic [COUNT_BITS-1:0]  run_r;
  logic [COUNT_BITS-1:0]  run_nxt;
  clsm_pkg::load_state_t  applied;
  logic                   is_lower;
  logic [CW-1:0]          run_ext;

  assign applied  = clsm_pkg::bw_to_state(applied_bandwidth);
  assign is_lower = load_state < applied;

  always_comb begin
    if (!is_lower) begin
      run_nxt = '0;
    end else if (&run_r) begin
      run_nxt = run_r;
    end else begin
      run_nxt = run_r + COUNT_BITS'(1);
    end
  end

  assign run_ext = CW'(run_nxt);

  always_comb begin
    if (!is_lower) begin
      next_state = load_state;
    end else if (run_ext < CW'(filter_count)) begin
      next_state = clsm_pkg::load_state_t'(applied - 2'd1);
    end else begin
      next_state = applied;
    end
  end

  assign lower_run = run_ext[clsm_pkg::RUN_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (advance) begin
      run_r <= run_nxt;
    end
  end

endmodule

@@ hw/rtl/cell_load_state_monitor_unit.sv @@
// Top level of the cell load state monitor: input register, load logic, result register.
//
//  channel | ports                               | role
//  --------+-------------------------------------+--------------------------------
//  in_     | valid/ready, user counts, bandwidth | one load report word
//  out_    | valid/ready, load, states, run      | one result word per report
//  cfg_    | we, index, wdata                    | register writes, no read-back
//
// One word per cycle is sustained while out_ready is high, as the multiply, compare and
// run counter update are combinational between the input and result registers. Reset
// clears the valid flags and run counter and returns the configuration registers to
// their defaults. A stalled output holds the result; the input register still takes a
// word while the result register is free or being emptied.
module cell_load_state_monitor_unit #(
  parameter int USER_BITS  = clsm_pkg::USER_BITS_DEF,
  parameter int COUNT_BITS = clsm_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [USER_BITS-1:0]             in_dch_users,
  input  logic [USER_BITS-1:0]             in_shared_users,
  input  logic                             in_has_access_channel,
  input  logic [1:0]                       in_applied_bandwidth,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [clsm_pkg::LOAD_OUT_W-1:0]  out_cell_load,
  output logic [1:0]                       out_load_state,
  output logic [1:0]                       out_next_state,
  output logic [1:0]                       out_next_bandwidth,
  output logic [clsm_pkg::RUN_OUT_W-1:0]   out_lower_run,
  input  logic                             cfg_we,
  input  logic [clsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  clsm_pkg::cfg_t cfg;

  logic                 s1_valid_r;
  logic [USER_BITS-1:0] s1_dch_r;
  logic [USER_BITS-1:0] s1_shr_r;
  logic                 s1_acc_r;
  logic [1:0]           s1_bw_r;

  logic                                out_valid_r;
  logic [clsm_pkg::LOAD_OUT_W-1:0]     out_load_r;
  clsm_pkg::load_state_t               out_lstate_r;
  clsm_pkg::load_state_t               out_nstate_r;
  logic [clsm_pkg::RUN_OUT_W-1:0]      out_run_r;

  logic [clsm_pkg::LOAD_OUT_W-1:0] cell_load;
  clsm_pkg::load_state_t           load_state;
  clsm_pkg::load_state_t           next_state;
  logic [clsm_pkg::RUN_OUT_W-1:0]  lower_run;
  logic                            advance;
  logic                            in_take;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  clsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  clsm_load_calc #(
    .USER_BITS (USER_BITS)
  ) u_load (
    .dch_users          (s1_dch_r),
    .shared_users       (s1_shr_r),
    .has_access_channel (s1_acc_r),
    .cfg                (cfg),
    .cell_load          (cell_load),
    .load_state         (load_state)
  );

  clsm_run_filter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_filt (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (advance),
    .load_state        (load_state),
    .applied_bandwidth (s1_bw_r),
    .filter_count      (cfg.filter_count),
    .next_state        (next_state),
    .lower_run         (lower_run)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_dch_r <= in_dch_users;
      s1_shr_r <= in_shared_users;
      s1_acc_r <= in_has_access_channel;
      s1_bw_r  <= in_applied_bandwidth;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_load_r   <= cell_load;
      out_lstate_r <= load_state;
      out_nstate_r <= next_state;
      out_run_r    <= lower_run;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_load      = out_load_r;
  assign out_load_state     = out_lstate_r;
  assign out_next_state     = out_nstate_r;
  assign out_next_bandwidth = clsm_pkg::state_to_bw(out_nstate_r);
  assign out_lower_run      = out_run_r;

endmodule

@@ tb/clsm_report_check.sv @@
// Checker for the cell load state monitor: tracks registers, predicts and compares result words.
module clsm_report_check
  import clsm_pkg::*;
#(
  parameter int USER_BITS  = USER_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [USER_BITS-1:0]  in_dch_users,
  input  logic [USER_BITS-1:0]  in_shared_users,
  input  logic                  in_has_access_channel,
  input  logic [1:0]            in_applied_bandwidth,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [LOAD_OUT_W-1:0] out_cell_load,
  input  logic [1:0]            out_load_state,
  input  logic [1:0]            out_next_state,
  input  logic [1:0]            out_next_bandwidth,
  input  logic [RUN_OUT_W-1:0]  out_lower_run,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           pending
);

  localparam logic [63:0] LOAD_MAX = (64'd1 << LOAD_OUT_W) - 64'd1;

  typedef struct packed {
    logic [LOAD_OUT_W-1:0] cell_load;
    load_state_t           load_state;
    load_state_t           next_state;
    logic [1:0]            next_bw;
    logic [RUN_OUT_W-1:0]  lower_run;
  } load_report_t;

  cfg_t                  regs;
  logic [COUNT_BITS-1:0] run_len;
  load_report_t          expected_q[$];
  int unsigned           word_idx;

  function automatic load_report_t classify_report(input logic [USER_BITS-1:0] dch,
                                                   input logic [USER_BITS-1:0] shr,
                                                   input logic acc,
                                                   input logic [1:0] bw);
    logic [63:0]  load;
    load_state_t  now_st;
    load_state_t  applied;
    load_state_t  next;
    load_report_t r;
    load = 64'(dch) * 64'(regs.dch_factor)
         + (64'(shr) + 64'(acc)) * 64'(regs.shared_factor);
    // high threshold wins even when the medium one is larger
    if (load >= 64'(regs.high_thresh)) now_st = ST_HIGH;
    else if (load >= 64'(regs.medium_thresh)) now_st = ST_MEDIUM;
    else now_st = ST_LOW;
    case (bw)
      BW_0K:   applied = ST_HIGH;
      BW_600K: applied = ST_MEDIUM;
      default: applied = ST_LOW;
    endcase
    if (now_st < applied) begin
      if (run_len != '1) run_len = run_len + 1'b1;
      if (32'(run_len) < 32'(regs.filter_count)) next = load_state_t'(applied - 2'd1);
      else next = applied;
    end else begin
      run_len = '0;
      next = now_st;
    end
    r.cell_load  = (load > LOAD_MAX) ? '1 : load[LOAD_OUT_W-1:0];
    r.load_state = now_st;
    r.next_state = next;
    case (next)
      ST_HIGH:   r.next_bw = BW_0K;
      ST_MEDIUM: r.next_bw = BW_600K;
      default:   r.next_bw = BW_1200K;
    endcase
    r.lower_run = RUN_OUT_W'(run_len);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    load_report_t got;
    load_report_t want;
    if (!rst_n) begin
      regs.dch_factor    = '0;
      regs.shared_factor = '0;
      regs.medium_thresh = '0;
      regs.high_thresh   = '0;
      regs.filter_count  = FILTER_COUNT_RST;
      run_len    = '0;
      word_idx   = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_cell_load, load_state_t'(out_load_state), load_state_t'(out_next_state),
                out_next_bandwidth, out_lower_run};
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("word %0d: result with nothing outstanding, load=%0d state=%0d",
                     word_idx, got.cell_load, got.load_state);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("word %0d: expected load=%0d state=%0d next=%0d bw=%0d run=%0d",
                       word_idx, want.cell_load, want.load_state, want.next_state,
                       want.next_bw, want.lower_run);
              $display("word %0d: actual   load=%0d state=%0d next=%0d bw=%0d run=%0d",
                       word_idx, got.cell_load, got.load_state, got.next_state,
                       got.next_bw, got.lower_run);
            end
            fail_count++;
          end
        end
        word_idx++;
      end
      if (in_valid && in_ready)
        expected_q.push_back(classify_report(in_dch_users, in_shared_users,
                                             in_has_access_channel, in_applied_bandwidth));
      if (cfg_we) begin
        case (cfg_index)
          CFG_DCH_FACTOR:    regs.dch_factor    = cfg_wdata[FACTOR_W-1:0];
          CFG_SHARED_FACTOR: regs.shared_factor = cfg_wdata[FACTOR_W-1:0];
          CFG_MEDIUM_THRESH: regs.medium_thresh = cfg_wdata[THRESH_W-1:0];
          CFG_HIGH_THRESH:   regs.high_thresh   = cfg_wdata[THRESH_W-1:0];
          CFG_FILTER_COUNT:  regs.filter_count  = cfg_wdata[FCOUNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/tb_cell_load_state_monitor_unit.sv @@
// Testbench top for the cell load state monitor: clock, reset, stimulus and verdict.
module tb_cell_load_state_monitor_unit;
  import clsm_pkg::*;

  localparam int USER_BITS  = USER_BITS_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int USER_MAX   = (1 << USER_BITS) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [THRESH_W-1:0]  THRESH_MAX     = '1;
  localparam logic [FACTOR_W-1:0]  FACTOR_MAX     = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [USER_BITS-1:0]  in_dch_users;
  logic [USER_BITS-1:0]  in_shared_users;
  logic                  in_has_access_channel;
  logic [1:0]            in_applied_bandwidth;
  logic                  out_valid;
  logic                  out_ready;
  logic [LOAD_OUT_W-1:0] out_cell_load;
  logic [1:0]            out_load_state;
  logic [1:0]            out_next_state;
  logic [1:0]            out_next_bandwidth;
  logic [RUN_OUT_W-1:0]  out_lower_run;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fail_count;
  int unsigned           pending;
  int                    send_idle_pct;
  int                    recv_idle_pct;

  cell_load_state_monitor_unit #(.USER_BITS(USER_BITS), .COUNT_BITS(COUNT_BITS)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_dch_users, .in_shared_users,
    .in_has_access_channel, .in_applied_bandwidth, .out_valid, .out_ready,
    .out_cell_load, .out_load_state, .out_next_state, .out_next_bandwidth,
    .out_lower_run, .cfg_we, .cfg_index, .cfg_wdata
  );

  clsm_report_check #(.USER_BITS(USER_BITS), .COUNT_BITS(COUNT_BITS)) report_check (
    .clk, .rst_n, .in_valid, .in_ready, .in_dch_users, .in_shared_users,
    .in_has_access_channel, .in_applied_bandwidth, .out_valid, .out_ready,
    .out_cell_load, .out_load_state, .out_next_state, .out_next_bandwidth,
    .out_lower_run, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #(20 * 200000);
    $display("cell_load_state_monitor_unit: mismatch");
    $finish;
  end

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drop valid and wait until every outstanding result word has come back
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic send_report(input logic [USER_BITS-1:0] dch,
                             input logic [USER_BITS-1:0] shr,
                             input logic acc,
                             input logic [1:0] bw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_dch_users          <= dch;
    in_shared_users       <= shr;
    in_has_access_channel <= acc;
    in_applied_bandwidth  <= bw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pick_settings;
    logic [FACTOR_W-1:0] df;
    logic [FACTOR_W-1:0] sf;
    logic [THRESH_W-1:0] med;
    logic [THRESH_W-1:0] hi;
    logic [THRESH_W-1:0] tmp;
    logic [FCOUNT_W-1:0] fc;
    int unsigned         span;
    df = ($urandom_range(5) == 0) ? FACTOR_MAX : FACTOR_W'($urandom);
    sf = ($urandom_range(5) == 0) ? '0 : FACTOR_W'($urandom);
    span = 1023 * int'(df) + 1024 * int'(sf);
    med = THRESH_W'($urandom_range(span));
    hi  = THRESH_W'($urandom_range(span));
    if (med > hi && $urandom_range(3) != 0) begin
      tmp = med;
      med = hi;
      hi  = tmp;
    end
    if ($urandom_range(7) == 0) hi = THRESH_MAX;
    if ($urandom_range(7) == 0) med = '0;
    case ($urandom_range(5))
      0:       fc = '0;
      1:       fc = 8'd1;
      2:       fc = '1;
      default: fc = FCOUNT_W'($urandom_range(2, 12));
    endcase
    // upper data bits beyond the register width must be dropped
    set_register(CFG_DCH_FACTOR, {12'($urandom), df});
    set_register(CFG_SHARED_FACTOR, {12'($urandom), sf});
    set_register(CFG_MEDIUM_THRESH, med);
    set_register(CFG_HIGH_THRESH, hi);
    set_register(CFG_FILTER_COUNT, {20'($urandom), fc});
  endtask

  // bursts mostly at one applied bandwidth, half light loads so lower runs build up
  task automatic send_random_reports(input int count);
    int                   left;
    int                   burst;
    int                   shape;
    logic [1:0]           bw;
    logic [USER_BITS-1:0] dch;
    logic [USER_BITS-1:0] shr;
    left = count;
    while (left > 0) begin
      bw = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        shape = $urandom_range(9);
        if (shape < 5) begin
          dch = USER_BITS'($urandom_range(15));
          shr = USER_BITS'($urandom_range(15));
        end else if (shape < 8) begin
          dch = USER_BITS'($urandom);
          shr = USER_BITS'($urandom);
        end else begin
          dch = USER_BITS'(USER_MAX);
          shr = $urandom_range(1) ? USER_BITS'(USER_MAX) : '0;
        end
        if ($urandom_range(19) == 0) bw = 2'($urandom_range(3));
        send_report(dch, shr, 1'($urandom_range(1)), bw);
      end
      left -= burst;
      if ($urandom_range(15) == 0) drain;
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_dch_users          = '0;
    in_shared_users       = '0;
    in_has_access_channel = 1'b0;
    in_applied_bandwidth  = BW_0K;
    out_ready             = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_DCH_FACTOR;
    cfg_wdata             = '0;
    send_idle_pct         = 12;
    recv_idle_pct         = 79;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero load already reaches the zero high threshold
    send_report('0, '0, 1'b0, BW_0K);
    send_report(USER_BITS'(USER_MAX), USER_BITS'(USER_MAX), 1'b1, 2'd3);
    drain;
    set_register(CFG_DCH_FACTOR, CFG_DATA_W'(FACTOR_MAX));
    set_register(CFG_SHARED_FACTOR, CFG_DATA_W'(FACTOR_MAX));
    set_register(CFG_MEDIUM_THRESH, 28'd1000);
    set_register(CFG_HIGH_THRESH, THRESH_MAX);
    set_register(CFG_FILTER_COUNT, 28'd2);
    send_report('0, '0, 1'b0, BW_0K);
    send_report('0, '0, 1'b0, BW_0K);
    send_report('0, '0, 1'b0, BW_0K);
    send_report('0, '0, 1'b1, BW_600K);
    send_report('0, '0, 1'b0, BW_600K);
    send_report('0, '0, 1'b0, 2'd3);
    send_report(USER_BITS'(USER_MAX), USER_BITS'(USER_MAX), 1'b1, BW_1200K);
    send_report(USER_BITS'(USER_MAX), '0, 1'b0, BW_0K);
    drain;
    // inverted thresholds, zero filter count
    set_register(CFG_MEDIUM_THRESH, THRESH_MAX);
    set_register(CFG_HIGH_THRESH, 28'd5000);
    set_register(CFG_FILTER_COUNT, 28'd0);
    send_report('0, '0, 1'b1, BW_0K);
    send_report('0, '0, 1'b0, BW_0K);
    send_report('0, '0, 1'b0, BW_600K);
    send_report(10'd1, '0, 1'b0, BW_1200K);
    drain;
    set_register(CFG_FILTER_COUNT, 28'd1);
    set_register(CFG_MEDIUM_THRESH, 28'd0);
    set_register(CFG_HIGH_THRESH, THRESH_MAX);
    set_register(CFG_UNUSED_IDX, 28'h5A5A5A5);
    send_report('0, '0, 1'b0, BW_0K);
    send_report(USER_BITS'(USER_MAX), USER_BITS'(USER_MAX), 1'b1, BW_600K);
    send_report(10'h2AA, 10'h155, 1'b0, BW_0K);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 79 : 0;
      recv_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 12 : 0;
      repeat (4) begin
        drain;
        pick_settings;
        send_random_reports(120);
      end
      if (mode == 2) begin
        // long run of lower reports drives the run counter into saturation
        drain;
        set_register(CFG_MEDIUM_THRESH, 28'd100);
        set_register(CFG_HIGH_THRESH, 28'd200);
        set_register(CFG_FILTER_COUNT, 28'd255);
        repeat (300) send_report('0, '0, 1'b0, BW_0K);
      end
    end

    drain;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("cell_load_state_monitor_unit: match");
    end else begin
      $display("cell_load_state_monitor_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ cell_load_state_monitor_unit.f @@
hw/rtl/clsm_pkg.sv
hw/rtl/clsm_cfg_regs.sv
hw/rtl/clsm_load_calc.sv
hw/rtl/clsm_run_filter.sv
hw/rtl/cell_load_state_monitor_unit.sv
tb/clsm_report_check.sv
tb/tb_cell_load_state_monitor_unit.sv
